[rtl/core/incscan_pkg.sv]
// Shared types, codes and character constants of the include directive scanner.
package incscan_pkg;

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 2;
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;

    localparam logic [REQ_W-1:0] REQ_CHAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EOL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SOF  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PATH_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABANDON   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MATCH  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPENER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PATH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IGNORE = 3'd4;

    localparam logic [IDX_W-1:0] WORD_LEN = 3'd7;

    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] path_char;
    } scan_result_t;

    typedef struct packed {
        logic              block_comment;
        logic              in_string;
        logic              escape_pending;
        logic              slash_pending;
        logic              star_pending;
        logic [MODE_W-1:0] scan_mode;
        logic [IDX_W-1:0]  match_index;
        logic              closer_is_quote;
        logic              path_started;
    } scan_state_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CHAR_W-1:0] word_letter(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] l;
        case (idx)
            3'd0: l = 8'h69;
            3'd1: l = 8'h6E;
            3'd2: l = 8'h63;
            3'd3: l = 8'h6C;
            3'd4: l = 8'h75;
            3'd5: l = 8'h64;
            3'd6: l = 8'h65;
            default: l = '0;
        endcase
        return l;
    endfunction

endpackage

[rtl/core/incscan_engine.sv]
// Scanner state register and the per-item next-state and result logic.
module incscan_engine
    import incscan_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [CHAR_W-1:0]  ch,
    output scan_result_t       result
);

    scan_state_t st_reg;
    scan_state_t st_next;

    function automatic scan_state_t scan_normal(input scan_state_t s,
                                                input logic [CHAR_W-1:0] c);
        scan_state_t n;
        logic        done;
        n    = s;
        done = 1'b0;
        if (s.block_comment) begin
            if (s.star_pending && c == CH_SLASH) begin
                n.block_comment = 1'b0;
                n.star_pending  = 1'b0;
            end else begin
                n.star_pending = (c == CH_STAR);
            end
            done = 1'b1;
        end
        if (!done && s.slash_pending) begin
            n.slash_pending = 1'b0;
            if (c == CH_STAR) begin
                n.block_comment = 1'b1;
                n.star_pending  = 1'b0;
                done            = 1'b1;
            end else if (c == CH_SLASH) begin
                n.scan_mode = MODE_IGNORE;
                done        = 1'b1;
            end
        end
        if (!done && !s.in_string && c == CH_SLASH) begin
            n.slash_pending = 1'b1;
            done            = 1'b1;
        end
        if (!done && c == CH_QUOTE && !s.escape_pending) begin
            n.in_string = !s.in_string;
            done        = 1'b1;
        end
        if (!done && s.in_string) begin
            n.escape_pending = !s.escape_pending && (c == CH_BSLASH);
            done             = 1'b1;
        end
        if (!done) begin
            n.escape_pending = 1'b0;
            if (c == CH_HASH) begin
                n.scan_mode   = MODE_MATCH;
                n.match_index = '0;
            end
        end
        return n;
    endfunction

    function automatic scan_state_t clear_line(input scan_state_t s);
        scan_state_t n;
        n               = '0;
        n.block_comment = s.block_comment;
        return n;
    endfunction

    always_comb begin
        st_next          = st_reg;
        result.valid     = 1'b0;
        result.kind      = KIND_PATH_CHAR;
        result.path_char = '0;
        if (step_en) begin
            case (req_type)
                REQ_EOL, REQ_SOF: begin
                    if (st_reg.scan_mode == MODE_PATH && st_reg.path_started) begin
                        result.valid = 1'b1;
                        result.kind  = KIND_ABANDON;
                    end
                    st_next = clear_line(st_reg);
                    if (req_type == REQ_SOF) begin
                        st_next.block_comment = 1'b0;
                    end
                end
                REQ_CHAR: begin
                    case (st_reg.scan_mode)
                        MODE_NORMAL: begin
                            st_next = scan_normal(st_reg, ch);
                        end
                        MODE_MATCH: begin
                            if (st_reg.match_index == '0 && is_space(ch)) begin
                                st_next = st_reg;
                            end else if (st_reg.match_index != WORD_LEN
                                         && ch == word_letter(st_reg.match_index)) begin
                                st_next.match_index = st_reg.match_index + 1'b1;
                                if (st_reg.match_index + 1'b1 == WORD_LEN) begin
                                    st_next.scan_mode   = MODE_OPENER;
                                    st_next.match_index = '0;
                                end
                            end else begin
                                st_next             = st_reg;
                                st_next.scan_mode   = MODE_NORMAL;
                                st_next.match_index = '0;
                                st_next             = scan_normal(st_next, ch);
                            end
                        end
                        MODE_OPENER: begin
                            if (!is_space(ch)) begin
                                if (ch == CH_LT || ch == CH_QUOTE) begin
                                    st_next.closer_is_quote = (ch == CH_QUOTE);
                                    st_next.path_started    = 1'b0;
                                    st_next.scan_mode       = MODE_PATH;
                                end else begin
                                    st_next.scan_mode = MODE_IGNORE;
                                end
                            end
                        end
                        MODE_PATH: begin
                            if (ch == (st_reg.closer_is_quote ? CH_QUOTE : CH_GT)) begin
                                st_next.scan_mode    = MODE_IGNORE;
                                st_next.path_started = 1'b0;
                                if (st_reg.path_started) begin
                                    result.valid = 1'b1;
                                    result.kind  = KIND_COMPLETE;
                                end
                            end else begin
                                st_next.path_started = 1'b1;
                                result.valid         = 1'b1;
                                result.kind          = KIND_PATH_CHAR;
                                result.path_char     = ch;
                            end
                        end
                        default: begin
                            st_next = st_reg;
                        end
                    endcase
                end
                default: begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

[rtl/core/include_directive_scanner.sv]
// Top level of the include directive scanner: input register, scan engine, result register.
//
// Input channel s_*: one item per handshake, s_tuser the request (character, end of
// line, start of file), s_tdata the text byte. Result channel m_*: m_tuser the result
// kind (path byte, path complete, path abandoned), m_tdata the path byte or zero.
// An item that causes no result produces nothing on m_*.
// A result is registered in the result register after its item leaves the input register.
// Throughput: one item per cycle while m_tready stays high; the scan state update is
// a single combinational step between the input register and the result register.
// Reset (aresetn low at a clock edge) empties both registers and clears all scan
// state, block comment tracking included.
// When the receiver stalls, the result is held in the result register; the input
// register still takes one more item, then s_tready falls until the result is taken.
module include_directive_scanner
    import incscan_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] ch
    input  logic [REQ_W-1:0]  s_tuser,   // [1:0] req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] path_char
    output logic [KIND_W-1:0] m_tuser    // [1:0] kind
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [REQ_W-1:0]  in_req_reg;
    logic [CHAR_W-1:0] in_ch_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              advance;
    logic              in_take;
    scan_result_t      result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    incscan_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .req_type (in_req_reg),
        .ch       (in_ch_reg),
        .result   (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_req_reg <= s_tuser;
            in_ch_reg  <= s_tdata;
        end
        if (advance && result.valid) begin
            out_kind_reg <= result.kind;
            out_char_reg <= result.path_char;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_kind_reg;

endmodule
